// ===== sv/bvrt_pkg.sv =====
// shared types, constants and arithmetic helpers for the box vertex transformer
package bvrt_pkg;

  localparam int NVERT   = 24;
  localparam int VCNT_W  = 5;
  localparam int NTRIG   = 6;
  localparam int TAG_W   = 3;

  localparam int SIZE_W  = 31;
  localparam int XYZ_W   = 32;
  localparam int ANG_W   = 16;
  localparam int CW      = 34;
  localparam int TW      = 32;
  localparam int PW      = CW + TW;
  localparam int RW      = 35;
  localparam int SW      = 36;
  localparam int OW      = 33;

  // trig slot order
  localparam int TSX = 0;
  localparam int TCX = 1;
  localparam int TSY = 2;
  localparam int TCY = 3;
  localparam int TSZ = 4;
  localparam int TCZ = 5;

  localparam int FULL_UNITS    = 23040;
  localparam int QUARTER_UNITS = 5760;
  localparam int QDIV          = 45;
  localparam int RECIP_SH      = 17;
  localparam int RECIP         = ((1 << RECIP_SH) + QDIV - 1) / QDIV;

  localparam logic [30:0] TRIG_ONE = 31'd1073741824;
  localparam logic [30:0] SC11     = 31'd3864;
  localparam logic [30:0] HC [5]   = '{31'd172272, 31'd5026995, 31'd85569306,
                                       31'd693598668, 31'd1686629713};

  localparam logic signed [SW-1:0] GMAX  = 36'sd8589934591;
  localparam logic signed [SW-1:0] S32HI = 36'sd2147483647;
  localparam logic signed [SW-1:0] S32LO = -36'sd2147483648;

  typedef logic [TAG_W-1:0]        tag_t;
  typedef logic signed [TW-1:0]    trig_t;
  typedef logic signed [CW-1:0]    crd_t;
  typedef logic signed [PW-1:0]    prod_t;
  typedef logic signed [OW-1:0]    off_t;
  typedef logic [22:0]             xtab_t [QDIV];

  function automatic xtab_t xtab_build();
    xtab_t t;
    for (int i = 0; i < QDIV; i++) begin
      t[i] = 23'((64'(i) << 23) / QDIV);
    end
    return t;
  endfunction

  localparam xtab_t XTAB = xtab_build();

  // bit0 = x, bit1 = y, bit2 = z
  function automatic logic [2:0] corner_sel(input logic [VCNT_W-1:0] k);
    logic [2:0] s;
    case (k)
      5'd0:  s = 3'd1;
      5'd1:  s = 3'd0;
      5'd2:  s = 3'd2;
      5'd3:  s = 3'd3;
      5'd4:  s = 3'd5;
      5'd5:  s = 3'd1;
      5'd6:  s = 3'd3;
      5'd7:  s = 3'd7;
      5'd8:  s = 3'd4;
      5'd9:  s = 3'd5;
      5'd10: s = 3'd7;
      5'd11: s = 3'd6;
      5'd12: s = 3'd0;
      5'd13: s = 3'd4;
      5'd14: s = 3'd6;
      5'd15: s = 3'd2;
      5'd16: s = 3'd6;
      5'd17: s = 3'd7;
      5'd18: s = 3'd3;
      5'd19: s = 3'd2;
      5'd20: s = 3'd0;
      5'd21: s = 3'd1;
      5'd22: s = 3'd5;
      5'd23: s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // product / 2^30, rounded half away from zero
  function automatic logic signed [RW-1:0] rndq(input prod_t p);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    logic signed [RW-1:0] rs;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    r   = (mag + PW'(1 << 29)) >> 30;
    rs  = RW'(r);
    return p[PW-1] ? -rs : rs;
  endfunction

  function automatic crd_t rot_sum(input prod_t a, input prod_t b, input logic sub);
    logic signed [SW-1:0] ra;
    logic signed [SW-1:0] rb;
    logic signed [SW-1:0] s;
    crd_t res;
    ra = SW'(rndq(a));
    rb = SW'(rndq(b));
    s  = sub ? ra - rb : ra + rb;
    if (s > GMAX) begin
      res = CW'(GMAX);
    end else if (s < -GMAX) begin
      res = CW'(-GMAX);
    end else begin
      res = CW'(s);
    end
    return res;
  endfunction

  function automatic logic [XYZ_W-1:0] sat32(input logic signed [SW-1:0] v);
    logic [XYZ_W-1:0] r;
    if (v > S32HI) begin
      r = XYZ_W'(S32HI);
    end else if (v < S32LO) begin
      r = XYZ_W'(S32LO);
    end else begin
      r = v[XYZ_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/box_vertex_rotate_translate.sv =====
// top level: box corners rotated about a pivot, translated and saturated
// a box waits in the front bank for its six sine and cosine values, then moves to the issue bank,
// which emits its 24 vertices through the vertex pipeline, one per cycle while out_ready allows;
// the next box's sine and cosine are formed while the current box still emits
// reset: synchronous active-low rst_n clears all valid bits and counters
module box_vertex_rotate_translate (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [30:0]          in_size_x,
  input  logic [30:0]          in_size_y,
  input  logic [30:0]          in_size_z,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_pos_z,
  input  logic signed [15:0]   in_angle_x,
  input  logic signed [15:0]   in_angle_y,
  input  logic signed [15:0]   in_angle_z,
  input  logic signed [31:0]   in_pivot_x,
  input  logic signed [31:0]   in_pivot_y,
  input  logic signed [31:0]   in_pivot_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_vert_x,
  output logic signed [31:0]   out_vert_y,
  output logic signed [31:0]   out_vert_z,
  output logic [4:0]           out_vertex_number,
  output logic                 out_last_vertex
);
  import bvrt_pkg::*;

  // front bank: box waiting for its trig values
  logic                       a_vld_r;
  logic [SIZE_W-1:0]          a_size_r [3];
  logic signed [XYZ_W-1:0]    a_pos_r  [3];
  logic signed [XYZ_W-1:0]    a_piv_r  [3];
  logic signed [ANG_W-1:0]    a_ang_r  [3];
  trig_t                      a_trig_r [NTRIG];
  logic [TAG_W-1:0]           tcnt_r, rcnt_r;

  // issue bank: box emitting vertices
  logic                       b_vld_r;
  logic [VCNT_W-1:0]          kcnt_r;
  logic [SIZE_W-1:0]          b_size_r [3];
  logic signed [XYZ_W-1:0]    b_piv_r  [3];
  off_t                       b_off_r  [3];
  trig_t                      b_trig_r [NTRIG];

  logic       in_acc, sc_go, a_done, adv, b_last, xfer;
  logic       sc_vld;
  tag_t       sc_tag;
  trig_t      sc_val;

  // vertex pipeline
  logic              v1_r, vm1_r, vr1_r, vm2_r, vr2_r, vm3_r, vr3_r, vo_r;
  logic [VCNT_W-1:0] k1_r, km1_r, kr1_r, km2_r, kr2_r, km3_r, kr3_r, ko_r;
  crd_t              d1_r [3];
  trig_t             t1_r [NTRIG], tm1_r [NTRIG], tr1_r [NTRIG], tm2_r [NTRIG];
  trig_t             tr2_r [NTRIG];
  off_t              o1_r [3], om1_r [3], or1_r [3], om2_r [3], or2_r [3], om3_r [3];
  off_t              or3_r [3];
  prod_t             pm1_r [4], pm2_r [4], pm3_r [4];
  crd_t              dxm1_r, dxr1_r, dxm2_r;
  crd_t              y1_r, z1_r, y1m2_r, y1r2_r, x2_r, z2_r, z2m3_r;
  crd_t              x3_r, y3_r, z2r3_r;
  logic [XYZ_W-1:0]  vx_r, vy_r, vz_r;

  logic [2:0]        sel;
  crd_t              d_nxt [3];

  assign in_ready = !a_vld_r;
  assign in_acc   = in_valid && in_ready;
  assign sc_go    = a_vld_r && (tcnt_r != TAG_W'(NTRIG));
  assign a_done   = a_vld_r && (rcnt_r == TAG_W'(NTRIG));
  assign adv      = !vo_r || out_ready;
  assign b_last   = b_vld_r && (kcnt_r == VCNT_W'(NVERT - 1)) && adv;
  assign xfer     = a_done && (!b_vld_r || b_last);

  bvrt_sincos u_sincos (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sc_go),
    .in_ang  (a_ang_r[tcnt_r[2:1]]),
    .in_cos  (tcnt_r[0]),
    .in_tag  (tcnt_r),
    .out_vld (sc_vld),
    .out_tag (sc_tag),
    .out_val (sc_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      tcnt_r  <= '0;
      rcnt_r  <= '0;
    end else if (in_acc) begin
      a_vld_r <= 1'b1;
      tcnt_r  <= '0;
      rcnt_r  <= '0;
    end else begin
      if (xfer) begin
        a_vld_r <= 1'b0;
      end
      if (sc_go) begin
        tcnt_r <= tcnt_r + 1'b1;
      end
      if (sc_vld) begin
        rcnt_r <= rcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_size_r <= '{in_size_x, in_size_y, in_size_z};
      a_pos_r  <= '{in_pos_x, in_pos_y, in_pos_z};
      a_piv_r  <= '{in_pivot_x, in_pivot_y, in_pivot_z};
      a_ang_r  <= '{in_angle_x, in_angle_y, in_angle_z};
    end
    if (sc_vld) begin
      a_trig_r[sc_tag] <= sc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      kcnt_r  <= '0;
    end else if (xfer) begin
      b_vld_r <= 1'b1;
      kcnt_r  <= '0;
    end else if (b_last) begin
      b_vld_r <= 1'b0;
    end else if (b_vld_r && adv) begin
      kcnt_r <= kcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      b_size_r <= a_size_r;
      b_piv_r  <= a_piv_r;
      b_trig_r <= a_trig_r;
      for (int i = 0; i < 3; i++) begin
        b_off_r[i] <= OW'(a_piv_r[i]) + OW'(a_pos_r[i]);
      end
    end
  end

  always_comb begin
    sel = corner_sel(kcnt_r);
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = (sel[i] ? crd_t'(CW'(b_size_r[i])) : crd_t'(0)) - CW'(b_piv_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vm1_r <= 1'b0;
      vr1_r <= 1'b0;
      vm2_r <= 1'b0;
      vr2_r <= 1'b0;
      vm3_r <= 1'b0;
      vr3_r <= 1'b0;
      vo_r  <= 1'b0;
    end else if (adv) begin
      v1_r  <= b_vld_r;
      vm1_r <= v1_r;
      vr1_r <= vm1_r;
      vm2_r <= vr1_r;
      vr2_r <= vm2_r;
      vm3_r <= vr2_r;
      vr3_r <= vm3_r;
      vo_r  <= vr3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // corner minus pivot
      k1_r <= kcnt_r;
      d1_r <= d_nxt;
      t1_r <= b_trig_r;
      o1_r <= b_off_r;
      // rotate about x: products
      km1_r    <= k1_r;
      tm1_r    <= t1_r;
      om1_r    <= o1_r;
      dxm1_r   <= d1_r[0];
      pm1_r[0] <= d1_r[1] * t1_r[TCX];
      pm1_r[1] <= d1_r[2] * t1_r[TSX];
      pm1_r[2] <= d1_r[1] * t1_r[TSX];
      pm1_r[3] <= d1_r[2] * t1_r[TCX];
      // rotate about x: sums
      kr1_r  <= km1_r;
      tr1_r  <= tm1_r;
      or1_r  <= om1_r;
      dxr1_r <= dxm1_r;
      y1_r   <= rot_sum(pm1_r[0], pm1_r[1], 1'b1);
      z1_r   <= rot_sum(pm1_r[2], pm1_r[3], 1'b0);
      // rotate about y: products
      km2_r    <= kr1_r;
      tm2_r    <= tr1_r;
      om2_r    <= or1_r;
      dxm2_r   <= dxr1_r;
      y1m2_r   <= y1_r;
      pm2_r[0] <= dxr1_r * tr1_r[TCY];
      pm2_r[1] <= z1_r * tr1_r[TSY];
      pm2_r[2] <= z1_r * tr1_r[TCY];
      pm2_r[3] <= dxr1_r * tr1_r[TSY];
      // rotate about y: sums
      kr2_r  <= km2_r;
      tr2_r  <= tm2_r;
      or2_r  <= om2_r;
      y1r2_r <= y1m2_r;
      x2_r   <= rot_sum(pm2_r[0], pm2_r[1], 1'b0);
      z2_r   <= rot_sum(pm2_r[2], pm2_r[3], 1'b1);
      // rotate about z: products
      km3_r    <= kr2_r;
      om3_r    <= or2_r;
      z2m3_r   <= z2_r;
      pm3_r[0] <= x2_r * tr2_r[TCZ];
      pm3_r[1] <= y1r2_r * tr2_r[TSZ];
      pm3_r[2] <= x2_r * tr2_r[TSZ];
      pm3_r[3] <= y1r2_r * tr2_r[TCZ];
      // rotate about z: sums
      kr3_r  <= km3_r;
      or3_r  <= om3_r;
      z2r3_r <= z2m3_r;
      x3_r   <= rot_sum(pm3_r[0], pm3_r[1], 1'b1);
      y3_r   <= rot_sum(pm3_r[2], pm3_r[3], 1'b0);
      // add pivot and position back, saturate
      ko_r <= kr3_r;
      vx_r <= sat32(SW'(x3_r) + SW'(or3_r[0]));
      vy_r <= sat32(SW'(y3_r) + SW'(or3_r[1]));
      vz_r <= sat32(SW'(z2r3_r) + SW'(or3_r[2]));
    end
  end

  assign out_valid         = vo_r;
  assign out_vert_x        = vx_r;
  assign out_vert_y        = vy_r;
  assign out_vert_z        = vz_r;
  assign out_vertex_number = ko_r;
  assign out_last_vertex   = (ko_r == VCNT_W'(NVERT - 1));

endmodule

// ===== sv/bvrt_sincos.sv =====
// pipelined sine / cosine unit, one angle per cycle, q30 result
module bvrt_sincos (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic signed [15:0]      in_ang,
  input  logic                    in_cos,
  input  bvrt_pkg::tag_t          in_tag,
  output logic                    out_vld,
  output bvrt_pkg::tag_t          out_tag,
  output bvrt_pkg::trig_t         out_val
);
  import bvrt_pkg::*;

  localparam logic signed [16:0] FULL17 = 17'(FULL_UNITS);
  localparam logic [15:0] FULL16 = 16'(FULL_UNITS);
  localparam logic [15:0] QTR16  = 16'(QUARTER_UNITS);
  localparam logic [12:0] QTR13  = 13'(QUARTER_UNITS);
  localparam int NH = 6;

  logic        v0_r, v1_r, v2_r, v3_r, ov_r;
  tag_t        tag0_r, tag1_r, tag2_r, tag3_r, otag_r;
  logic [14:0] r0_r;
  logic [12:0] fq1_r, fq2_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [7:0]  qf2_r;
  logic [30:0] x3_r;
  trig_t       oval_r;

  logic        pv_r   [NH];
  tag_t        ptag_r [NH];
  logic [30:0] px_r   [NH];
  logic [30:0] pz_r   [NH];
  logic [30:0] ps_r   [NH];
  logic        pneg_r [NH];

  logic signed [16:0] a17, w17;
  logic [15:0]        r16, rc16;
  logic [15:0]        f16;
  logic [12:0]        fq_nxt;
  logic               neg_nxt;
  logic [24:0]        qp;
  logic [12:0]        rf13;
  logic [5:0]         rf;
  logic [30:0]        x_nxt;
  logic [61:0]        xx;
  logic [61:0]        hp [NH-1];
  logic [61:0]        fp;
  logic [31:0]        fv;
  logic [30:0]        fc;

  always_comb begin
    a17 = 17'(in_ang);
    if (a17 < -FULL17) begin
      w17 = a17 + FULL17 + FULL17;
    end else if (a17 < 17'sd0) begin
      w17 = a17 + FULL17;
    end else if (a17 >= FULL17) begin
      w17 = a17 - FULL17;
    end else begin
      w17 = a17;
    end
    r16  = 16'(w17);
    rc16 = r16 + QTR16;
    if (in_cos) begin
      r16 = (rc16 >= FULL16) ? rc16 - FULL16 : rc16;
    end
  end

  always_comb begin
    if (r0_r < 15'(QUARTER_UNITS)) begin
      f16 = 16'(r0_r);
      neg_nxt = 1'b0;
      fq_nxt = 13'(f16);
    end else if (r0_r < 15'(2 * QUARTER_UNITS)) begin
      f16 = 16'(r0_r) - QTR16;
      neg_nxt = 1'b0;
      fq_nxt = QTR13 - 13'(f16);
    end else if (r0_r < 15'(3 * QUARTER_UNITS)) begin
      f16 = 16'(r0_r) - 16'(2 * QUARTER_UNITS);
      neg_nxt = 1'b1;
      fq_nxt = 13'(f16);
    end else begin
      f16 = 16'(r0_r) - 16'(3 * QUARTER_UNITS);
      neg_nxt = 1'b1;
      fq_nxt = QTR13 - 13'(f16);
    end
  end

  assign qp    = 25'(fq1_r) * 25'(RECIP);
  assign rf13  = fq2_r - 13'(qf2_r) * 13'(QDIV);
  assign rf    = rf13[5:0];
  assign x_nxt = {qf2_r, 23'd0} + 31'(XTAB[rf]);
  assign xx    = 62'(x3_r) * 62'(x3_r);

  always_comb begin
    for (int h = 0; h < NH - 1; h++) begin
      hp[h] = 62'(ps_r[h]) * 62'(pz_r[h]);
    end
    fp = 62'(ps_r[NH-1]) * 62'(px_r[NH-1]);
    fv = fp[61:30];
    fc = (fv > 32'(TRIG_ONE)) ? TRIG_ONE : fv[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
      for (int h = 0; h < NH; h++) begin
        pv_r[h] <= 1'b0;
      end
    end else begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      pv_r[0] <= v3_r;
      for (int h = 1; h < NH; h++) begin
        pv_r[h] <= pv_r[h-1];
      end
      ov_r <= pv_r[NH-1];
    end
  end

  always_ff @(posedge clk) begin
    tag0_r <= in_tag;
    r0_r   <= r16[14:0];
    tag1_r <= tag0_r;
    fq1_r  <= fq_nxt;
    neg1_r <= neg_nxt;
    tag2_r <= tag1_r;
    fq2_r  <= fq1_r;
    qf2_r  <= qp[24:17];
    neg2_r <= neg1_r;
    tag3_r <= tag2_r;
    x3_r   <= x_nxt;
    neg3_r <= neg2_r;
    ptag_r[0] <= tag3_r;
    px_r[0]   <= x3_r;
    pz_r[0]   <= xx[60:30];
    ps_r[0]   <= SC11;
    pneg_r[0] <= neg3_r;
    for (int h = 1; h < NH; h++) begin
      ptag_r[h] <= ptag_r[h-1];
      px_r[h]   <= px_r[h-1];
      pz_r[h]   <= pz_r[h-1];
      ps_r[h]   <= HC[h-1] - hp[h-1][60:30];
      pneg_r[h] <= pneg_r[h-1];
    end
    otag_r <= ptag_r[NH-1];
    oval_r <= pneg_r[NH-1] ? -trig_t'(TW'(fc)) : trig_t'(TW'(fc));
  end

  assign out_vld = ov_r;
  assign out_tag = otag_r;
  assign out_val = oval_r;

endmodule

// ===== test/tb.sv =====
// testbench for the box vertex transformer: directed and random boxes in, 24 checked corners out per box
`timescale 1ns / 100ps

module tb;
  import bvrt_pkg::*;

  typedef struct packed {
    logic [30:0]        sx, sy, sz;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] ax, ay, az;
    logic signed [31:0] vx, vy, vz;
  } box_t;

  typedef struct packed {
    logic signed [31:0] x, y, z;
    logic [4:0]         num;
    logic               last;
  } vert_t;

  localparam longint QONE = 64'sd1073741824;
  localparam longint GLIM = 64'sd8589934591;
  localparam logic [2:0] CORNER_MAP [24] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd5, 3'd1, 3'd3, 3'd7,
                                             3'd4, 3'd5, 3'd7, 3'd6, 3'd0, 3'd4, 3'd6, 3'd2,
                                             3'd6, 3'd7, 3'd3, 3'd2, 3'd0, 3'd1, 3'd5, 3'd4};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [30:0] in_size_x = '0, in_size_y = '0, in_size_z = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic signed [31:0] in_pivot_x = '0, in_pivot_y = '0, in_pivot_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_vert_x, out_vert_y, out_vert_z;
  logic [4:0] out_vertex_number;
  logic out_last_vertex;

  box_t  box_q[$];
  vert_t corner_q[$];
  int    errors = 0;
  bit    hold_for_drain = 1'b0;
  int    in_gap = 0;
  int    out_gap = 0;

  box_vertex_rotate_translate dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint quad_sine(input int f);
    longint unsigned x, z, s;
    longint unsigned c[6];
    c = '{64'd3864, 64'd172272, 64'd5026995, 64'd85569306, 64'd693598668, 64'd1686629713};
    x = (longint'(f) << 30) / 5760;
    z = (x * x) >> 30;
    s = c[0];
    for (int i = 1; i < 6; i++) s = c[i] - ((s * z) >> 30);
    s = (s * x) >> 30;
    return (s > QONE) ? QONE : longint'(s);
  endfunction

  function automatic longint sine_of(input int r);
    int q, f;
    longint v;
    q = r / 5760;
    f = r % 5760;
    v = (q % 2) ? quad_sine(5760 - f) : quad_sine(f);
    return (q >= 2) ? -v : v;
  endfunction

  function automatic longint scale_round(input longint v, input longint t);
    longint unsigned mv, mt, r;
    mv = (v < 0) ? -v : v;
    mt = (t < 0) ? -t : t;
    r = (mv * mt + 64'd536870912) >> 30;
    return ((v < 0) != (t < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_guard(input longint v);
    if (v > GLIM) return GLIM;
    if (v < -GLIM) return -GLIM;
    return v;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic predict_corners(input box_t b);
    longint sz[3], ps[3], pv[3], sn[3], cs[3];
    longint dx, dy, dz, y1, z1, x2, z2, x3, y3;
    int ang[3];
    int r;
    logic [2:0] sel;
    vert_t v;
    sz = '{b.sx, b.sy, b.sz};
    ps = '{b.px, b.py, b.pz};
    pv = '{b.vx, b.vy, b.vz};
    ang = '{b.ax, b.ay, b.az};
    for (int i = 0; i < 3; i++) begin
      r = ((ang[i] % 23040) + 23040) % 23040;
      sn[i] = sine_of(r);
      cs[i] = sine_of((r + 5760) % 23040);
    end
    for (int k = 0; k < 24; k++) begin
      sel = CORNER_MAP[k];
      dx = (sel[0] ? sz[0] : 0) - pv[0];
      dy = (sel[1] ? sz[1] : 0) - pv[1];
      dz = (sel[2] ? sz[2] : 0) - pv[2];
      y1 = clamp_guard(scale_round(dy, cs[0]) - scale_round(dz, sn[0]));
      z1 = clamp_guard(scale_round(dy, sn[0]) + scale_round(dz, cs[0]));
      x2 = clamp_guard(scale_round(dx, cs[1]) + scale_round(z1, sn[1]));
      z2 = clamp_guard(scale_round(z1, cs[1]) - scale_round(dx, sn[1]));
      x3 = clamp_guard(scale_round(x2, cs[2]) - scale_round(y1, sn[2]));
      y3 = clamp_guard(scale_round(x2, sn[2]) + scale_round(y1, cs[2]));
      v.x = clamp32(x3 + pv[0] + ps[0]);
      v.y = clamp32(y3 + pv[1] + ps[1]);
      v.z = clamp32(z2 + pv[2] + ps[2]);
      v.num = 5'(k);
      v.last = (k == 23);
      corner_q = {corner_q, v};
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    int p;
    p = $urandom_range(0, 9);
    if (p < 2) return 16'(5760 * $urandom_range(0, 8) - 23040);
    if (p < 8) return 16'($urandom_range(0, 46080) - 23040);
    return 16'($urandom);
  endfunction

  function automatic box_t random_box();
    box_t b;
    b.sx = 31'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00ffffff));
    b.sy = 31'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00ffffff));
    b.sz = 31'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00ffffff));
    b.px = pick_coord();
    b.py = pick_coord();
    b.pz = pick_coord();
    b.vx = pick_coord();
    b.vy = pick_coord();
    b.vz = pick_coord();
    b.ax = pick_angle();
    b.ay = pick_angle();
    b.az = pick_angle();
    return b;
  endfunction

  initial begin
    box_t b;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    b = '0;
    box_q = {box_q, b};
    b.sx = '1; b.sy = '1; b.sz = '1;
    b.px = 32'h7fffffff; b.py = 32'h7fffffff; b.pz = 32'h7fffffff;
    box_q = {box_q, b};
    b.px = 32'h80000000; b.py = 32'h80000000; b.pz = 32'h80000000;
    b.vx = 32'h7fffffff; b.vy = 32'h80000000; b.vz = 32'h7fffffff;
    b.ax = 16'sd23040; b.ay = -16'sd23040; b.az = 16'sd11520;
    box_q = {box_q, b};
    b.ax = 16'sh7fff; b.ay = 16'sh8000; b.az = -16'sd1;
    box_q = {box_q, b};
    for (int i = 0; i < 9; i++) begin
      b = '0;
      b.sx = 31'h10000; b.sy = 31'h20000; b.sz = 31'h30000;
      b.vx = 32'h8000; b.vy = 32'h8000; b.vz = 32'h8000;
      b.ax = 16'(5760 * (i % 3)); b.ay = 16'(5760 * (i / 3)); b.az = 16'(2880 * i - 11520);
      box_q = {box_q, b};
    end
    b.ax = 16'sd23041; b.ay = -16'sd30000; b.az = 16'sd30000;
    box_q = {box_q, b};
    for (int i = 0; i < 90; i++) box_q = {box_q, random_box()};
    wait (box_q.size() == 0 && !in_valid);
    hold_for_drain = 1'b1;
    wait (corner_q.size() == 0);
    repeat (40) @(posedge clk);
    hold_for_drain = 1'b0;
    for (int i = 0; i < 80; i++) box_q = {box_q, random_box()};
    wait (box_q.size() == 0 && !in_valid);
    wait (corner_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    box_t b;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_corners({in_size_x, in_size_y, in_size_z, in_pos_x, in_pos_y, in_pos_z,
                         in_angle_x, in_angle_y, in_angle_z, in_pivot_x, in_pivot_y,
                         in_pivot_z});
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (box_q.size() > 0 && !hold_for_drain) begin
          b = box_q.pop_front();
          in_valid <= 1'b1;
          in_size_x <= b.sx; in_size_y <= b.sy; in_size_z <= b.sz;
          in_pos_x <= b.px; in_pos_y <= b.py; in_pos_z <= b.pz;
          in_angle_x <= b.ax; in_angle_y <= b.ay; in_angle_z <= b.az;
          in_pivot_x <= b.vx; in_pivot_y <= b.vy; in_pivot_z <= b.vz;
          in_gap <= pick_gap() * 8;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    vert_t w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (corner_q.size() == 0) begin
          report_mismatch("unexpected item", out_vertex_number, 0);
        end else begin
          w = corner_q.pop_front();
          if (out_vert_x !== w.x) report_mismatch("vert_x", out_vert_x, w.x);
          if (out_vert_y !== w.y) report_mismatch("vert_y", out_vert_y, w.y);
          if (out_vert_z !== w.z) report_mismatch("vert_z", out_vert_z, w.z);
          if (out_vertex_number !== w.num)
            report_mismatch("vertex_number", out_vertex_number, w.num);
          if (out_last_vertex !== w.last)
            report_mismatch("last_vertex", out_last_vertex, w.last);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

endmodule
